### rtl/core/fbc_pkg.sv
// Shared constants, codes and types of the frustum box cull unit.
package fbc_pkg;

    localparam int PLANE_COUNT = 6;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;

    localparam int KIND_W   = 2;
    localparam int POS_W    = 24;
    localparam int EXT_W    = 23;
    localparam int CENTER_W = POS_W + 1;
    localparam int CORNER_W = CENTER_W + 1;
    localparam int NORM_W   = 12;
    localparam int DIST_W   = 28;
    localparam int DIST_SH  = 10;
    localparam int PROD_W   = CORNER_W + NORM_W;
    localparam int ACC_W    = PROD_W + 2;

    // Shape kinds; the unused fourth code behaves like KIND_NONE.
    localparam logic [KIND_W-1:0] KIND_BOX    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SPHERE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_NONE   = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_LEFT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_RIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_BOTTOM = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_TOP    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_NEAR   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_FAR    = 3'd5;

    typedef struct packed {
        logic signed [DIST_W-1:0] distance;
        logic signed [NORM_W-1:0] nz;
        logic signed [NORM_W-1:0] ny;
        logic signed [NORM_W-1:0] nx;
    } plane_t;

    typedef logic signed [CENTER_W-1:0] center_t;
    typedef logic        [EXT_W-1:0]    half_t;
    typedef logic signed [CORNER_W-1:0] corner_t;
    typedef logic signed [NORM_W-1:0]   norm_t;
    typedef logic signed [PROD_W-1:0]   prod_t;
    typedef logic signed [ACC_W-1:0]    acc_t;

endpackage

### rtl/core/fbc_if.sv
// Channel interfaces of the frustum box cull unit: objects, results and configuration.
interface fbc_obj_if;
    logic                             valid;
    logic                             ready;
    logic [fbc_pkg::KIND_W-1:0]       shape_kind;
    logic signed [fbc_pkg::POS_W-1:0] pos_x;
    logic signed [fbc_pkg::POS_W-1:0] pos_y;
    logic signed [fbc_pkg::POS_W-1:0] pos_z;
    logic signed [fbc_pkg::POS_W-1:0] offset_x;
    logic signed [fbc_pkg::POS_W-1:0] offset_y;
    logic signed [fbc_pkg::POS_W-1:0] offset_z;
    logic [fbc_pkg::EXT_W-1:0]        extent_x;
    logic [fbc_pkg::EXT_W-1:0]        extent_y;
    logic [fbc_pkg::EXT_W-1:0]        extent_z;
    logic [fbc_pkg::EXT_W-1:0]        sphere_radius;

    modport source (
        output valid, shape_kind, pos_x, pos_y, pos_z, offset_x, offset_y, offset_z,
               extent_x, extent_y, extent_z, sphere_radius,
        input  ready
    );
    modport sink (
        input  valid, shape_kind, pos_x, pos_y, pos_z, offset_x, offset_y, offset_z,
               extent_x, extent_y, extent_z, sphere_radius,
        output ready
    );
endinterface

interface fbc_vis_if;
    logic valid;
    logic ready;
    logic visible;

    modport source (output valid, visible, input ready);
    modport sink (input valid, visible, output ready);
endinterface

interface fbc_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [fbc_pkg::CFG_IDX_W-1:0]   index;
    logic [fbc_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

### rtl/core/frustum_box_cull_unit.sv
// Frustum box cull unit: tests one object's world box against six clip planes.
//
// Usage: objects arrive as requests on the obj channel (valid/ready); each
// yields exactly one request on the result channel carrying the visible bit.
// The six planes are written through the cfg channel, index 0 to 5 in the
// order left, right, bottom, top, near, far; other indexes are dropped. The
// cfg channel is always ready. Planes may change only while the unit is idle.
//
// An accepted object passes four registered steps to its result: world center,
// box min/max, eighteen corner products, then the per-plane sums and the
// visibility decision in the output register. One object is accepted every
// cycle while the result channel is not stalled; that rate is set by the
// four-stage pipeline, each stage holding its own valid bit.
//
// When the receiver stalls, each stage holds while the stage after it is
// full, so empty stages keep filling and obj.ready drops only once every
// stage holds an object. Reset clears all valid bits and all planes to zero;
// a zero plane never rejects, so every object is visible until planes are set.
module frustum_box_cull_unit (
    input  logic      clk,
    input  logic      rst_n,
    fbc_obj_if.sink   obj,
    fbc_vis_if.source result,
    fbc_cfg_if.sink   cfg
);
    import fbc_pkg::*;

    // Plane registers.
    plane_t planes_reg [PLANE_COUNT];

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PLANE_COUNT; i++)
            begin
                planes_reg[i] <= '0;
            end
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_PLANE_LEFT:   planes_reg[0] <= cfg.data;
                REG_PLANE_RIGHT:  planes_reg[1] <= cfg.data;
                REG_PLANE_BOTTOM: planes_reg[2] <= cfg.data;
                REG_PLANE_TOP:    planes_reg[3] <= cfg.data;
                REG_PLANE_NEAR:   planes_reg[4] <= cfg.data;
                REG_PLANE_FAR:    planes_reg[5] <= cfg.data;
                default:          ;
            endcase
        end
    end

    // Stage enables: a stage loads when it is empty or its successor moves.
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, out_valid_reg;
    logic s1_valid_next, s2_valid_next, s3_valid_next, out_valid_next;
    logic s1_en, s2_en, s3_en, out_en;

    assign out_en    = !out_valid_reg || result.ready;
    assign s3_en     = !s3_valid_reg || out_en;
    assign s2_en     = !s2_valid_reg || s3_en;
    assign s1_en     = !s1_valid_reg || s2_en;
    assign obj.ready = s1_en;

    assign s1_valid_next  = s1_en  ? obj.valid    : s1_valid_reg;
    assign s2_valid_next  = s2_en  ? s1_valid_reg : s2_valid_reg;
    assign s3_valid_next  = s3_en  ? s2_valid_reg : s3_valid_reg;
    assign out_valid_next = out_en ? s3_valid_reg : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            s3_valid_reg  <= s3_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Stage 1: world center and half size per axis.
    center_t center_reg [3];
    center_t center_next [3];
    half_t   half_reg [3];
    half_t   half_next [3];
    logic signed [POS_W-1:0] pos_v [3];
    logic signed [POS_W-1:0] off_v [3];
    logic        [EXT_W-1:0] ext_v [3];

    assign pos_v[0] = obj.pos_x;
    assign pos_v[1] = obj.pos_y;
    assign pos_v[2] = obj.pos_z;
    assign off_v[0] = obj.offset_x;
    assign off_v[1] = obj.offset_y;
    assign off_v[2] = obj.offset_z;
    assign ext_v[0] = obj.extent_x;
    assign ext_v[1] = obj.extent_y;
    assign ext_v[2] = obj.extent_z;

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            case (obj.shape_kind)
                KIND_BOX:
                begin
                    center_next[a] = CENTER_W'(pos_v[a]) + CENTER_W'(off_v[a]);
                    half_next[a]   = ext_v[a];
                end
                KIND_SPHERE:
                begin
                    center_next[a] = CENTER_W'(pos_v[a]) + CENTER_W'(off_v[a]);
                    half_next[a]   = obj.sphere_radius;
                end
                default:
                begin
                    // No collider: the box sits on the position, with the extents as half sizes.
                    center_next[a] = CENTER_W'(pos_v[a]);
                    half_next[a]   = ext_v[a];
                end
            endcase
        end
    end

    // Stage 2: box min and max corners.
    corner_t lo_reg [3];
    corner_t hi_reg [3];
    corner_t lo_next [3];
    corner_t hi_next [3];

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            lo_next[a] = CORNER_W'(center_reg[a]) - $signed({3'b000, half_reg[a]});
            hi_next[a] = CORNER_W'(center_reg[a]) + $signed({3'b000, half_reg[a]});
        end
    end

    // Stage 3: per plane, pick the corner farthest along the normal and multiply.
    prod_t prod_reg [PLANE_COUNT][3];
    prod_t prod_next [PLANE_COUNT][3];
    norm_t norm_v [PLANE_COUNT][3];

    always_comb
    begin
        for (int p = 0; p < PLANE_COUNT; p++)
        begin
            norm_v[p][0] = planes_reg[p].nx;
            norm_v[p][1] = planes_reg[p].ny;
            norm_v[p][2] = planes_reg[p].nz;
            for (int a = 0; a < 3; a++)
            begin
                if (norm_v[p][a][NORM_W-1])
                begin
                    prod_next[p][a] = PROD_W'(lo_reg[a]) * PROD_W'(norm_v[p][a]);
                end
                else
                begin
                    prod_next[p][a] = PROD_W'(hi_reg[a]) * PROD_W'(norm_v[p][a]);
                end
            end
        end
    end

    // Stage 4: plane sums; the object is visible when no sum is negative.
    acc_t acc_v [PLANE_COUNT];
    logic visible_reg;
    logic visible_next;

    always_comb
    begin
        visible_next = 1'b1;
        for (int p = 0; p < PLANE_COUNT; p++)
        begin
            acc_v[p] = $signed({{(ACC_W-DIST_W-DIST_SH){planes_reg[p].distance[DIST_W-1]}},
                                planes_reg[p].distance, {DIST_SH{1'b0}}})
                     + $signed({{(ACC_W-PROD_W){prod_reg[p][0][PROD_W-1]}}, prod_reg[p][0]})
                     + $signed({{(ACC_W-PROD_W){prod_reg[p][1][PROD_W-1]}}, prod_reg[p][1]})
                     + $signed({{(ACC_W-PROD_W){prod_reg[p][2][PROD_W-1]}}, prod_reg[p][2]});
            if (acc_v[p][ACC_W-1])
            begin
                visible_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_en)
        begin
            center_reg <= center_next;
            half_reg   <= half_next;
        end
        if (s2_en)
        begin
            lo_reg <= lo_next;
            hi_reg <= hi_next;
        end
        if (s3_en)
        begin
            prod_reg <= prod_next;
        end
        if (out_en)
        begin
            visible_reg <= visible_next;
        end
    end

    assign result.valid   = out_valid_reg;
    assign result.visible = visible_reg;

endmodule

### rtl/core/fbc_checker.sv
// Port-level checker of the frustum box cull unit and its bind.
module fbc_checker (
    input logic clk,
    input logic rst_n,
    input logic obj_valid,
    input logic obj_ready,
    input logic res_valid,
    input logic res_ready,
    input logic res_visible
);

    // A stalled result stays offered and keeps its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_visible))
        else $error("result dropped or changed while stalled");

    // A receiver that takes results never backs up the object side.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_ready |-> obj_ready)
        else $error("object side stalled while result side is ready");

    // With the receiver ready meanwhile, an accepted object's result shows once it has passed the stage registers.
    assert property (@(posedge clk) disable iff (!rst_n)
        (obj_valid && obj_ready) ##1 res_ready ##1 res_ready ##1 res_ready |=> res_valid)
        else $error("result missing four cycles after an accepted object");

endmodule

bind frustum_box_cull_unit fbc_checker u_fbc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .obj_valid   (obj.valid),
    .obj_ready   (obj.ready),
    .res_valid   (result.valid),
    .res_ready   (result.ready),
    .res_visible (result.visible)
);

### verif/tb_top.sv
// Self-checking testbench for the frustum box cull unit with a bit-exact visibility predictor.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import fbc_pkg::*;

    localparam int CYCLE_LIMIT = 500000;

    // Indexes past the last plane; writes to them must be dropped.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

    // The unused fourth shape code.
    localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0]           kind;
        logic [2:0][POS_W-1:0]       pos;
        logic [2:0][POS_W-1:0]       off;
        logic [2:0][EXT_W-1:0]       ext;
        logic [EXT_W-1:0]            radius;
    } object_t;

    logic clk;
    logic rst_n;

    fbc_obj_if obj_bus ();
    fbc_vis_if vis_bus ();
    fbc_cfg_if cfg_bus ();

    frustum_box_cull_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .obj    (obj_bus),
        .result (vis_bus),
        .cfg    (cfg_bus)
    );

    plane_t  plane_regs [PLANE_COUNT];
    bit      pending_visibility [$];
    int      mismatch_count;
    int      object_count;
    int      visible_count;
    int      culled_count;
    int      plane_write_count;
    int      src_idle_pct;
    int      sink_stall_pct;
    longint  cycle_count;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Returns 1 when no plane has the box's farthest corner on its negative side.
    function automatic bit predict_visible(object_t o);
        longint lo [3];
        longint hi [3];
        longint norm [3];
        longint center;
        longint half;
        longint acc;
        plane_t p;
        for (int a = 0; a < 3; a++)
        begin
            center = longint'($signed(o.pos[a]));
            if (o.kind == KIND_BOX || o.kind == KIND_SPHERE)
                center += longint'($signed(o.off[a]));
            half = (o.kind == KIND_SPHERE) ? longint'(o.radius) : longint'(o.ext[a]);
            lo[a] = center - half;
            hi[a] = center + half;
        end
        for (int i = 0; i < PLANE_COUNT; i++)
        begin
            p = plane_regs[i];
            norm[0] = longint'($signed(p.nx));
            norm[1] = longint'($signed(p.ny));
            norm[2] = longint'($signed(p.nz));
            // Distance is Q.8 and the products are Q.18.
            acc = longint'($signed(p.distance)) * (longint'(1) << DIST_SH);
            for (int a = 0; a < 3; a++)
                acc += norm[a] * ((norm[a] >= 0) ? hi[a] : lo[a]);
            if (acc < 0)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic object_t make_object(input logic [KIND_W-1:0] kind, input int p [3],
                                            input int o [3], input int e [3], input int r);
        object_t obj;
        obj.kind = kind;
        for (int a = 0; a < 3; a++)
        begin
            obj.pos[a] = POS_W'(p[a]);
            obj.off[a] = POS_W'(o[a]);
            obj.ext[a] = EXT_W'(e[a]);
        end
        obj.radius = EXT_W'(r);
        return obj;
    endfunction

    function automatic plane_t make_plane(input int nx, input int ny, input int nz,
                                          input int distance);
        plane_t p;
        p.nx       = NORM_W'(nx);
        p.ny       = NORM_W'(ny);
        p.nz       = NORM_W'(nz);
        p.distance = DIST_W'(distance);
        return p;
    endfunction

    // Mostly objects scattered around the origin; a fifth are raw random bits.
    function automatic object_t random_object();
        object_t o;
        int v;
        if ($urandom_range(9) < 2)
        begin
            o.kind = KIND_W'($urandom);
            for (int a = 0; a < 3; a++)
            begin
                o.pos[a] = POS_W'($urandom);
                o.off[a] = POS_W'($urandom);
                o.ext[a] = EXT_W'($urandom);
            end
            o.radius = EXT_W'($urandom);
        end
        else
        begin
            o.kind = ($urandom_range(7) == 0) ? KIND_SPARE : KIND_W'($urandom_range(2));
            for (int a = 0; a < 3; a++)
            begin
                v = int'($urandom_range(1 << 18)) - (1 << 17);
                o.pos[a] = POS_W'(v);
                v = int'($urandom_range(1 << 13)) - (1 << 12);
                o.off[a] = POS_W'(v);
                o.ext[a] = EXT_W'($urandom_range(1 << 14));
            end
            o.radius = EXT_W'($urandom_range(1 << 14));
        end
        return o;
    endfunction

    // Most scene planes keep the origin on the positive side so that nearby objects survive.
    function automatic plane_t random_plane(input bit raw);
        plane_t p;
        int d;
        if (raw)
            p = {$urandom, $urandom};
        else if ($urandom_range(5) == 0)
            p = '0;
        else
        begin
            d = int'($urandom_range(1 << 17));
            if ($urandom_range(7) == 0)
                d = -d;
            p = make_plane(int'($urandom), int'($urandom), int'($urandom), d);
        end
        return p;
    endfunction

    // Leaves valid high so that back-to-back writes need no extra step.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input plane_t value);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        do
            @(posedge clk);
        while (!(cfg_bus.valid && cfg_bus.ready));
        if (idx < PLANE_COUNT)
            plane_regs[idx] = value;
        plane_write_count++;
    endtask

    task automatic end_reg_writes();
        cfg_bus.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic program_planes(input plane_t p [PLANE_COUNT]);
        write_reg(REG_PLANE_LEFT,   p[0]);
        write_reg(REG_PLANE_RIGHT,  p[1]);
        write_reg(REG_PLANE_BOTTOM, p[2]);
        write_reg(REG_PLANE_TOP,    p[3]);
        write_reg(REG_PLANE_NEAR,   p[4]);
        write_reg(REG_PLANE_FAR,    p[5]);
        end_reg_writes();
    endtask

    task automatic send_object(input object_t o);
        int gap;
        gap = 0;
        while (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct)
            gap++;
        if (gap > 0)
        begin
            obj_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        obj_bus.valid         <= 1'b1;
        obj_bus.shape_kind    <= o.kind;
        obj_bus.pos_x         <= o.pos[0];
        obj_bus.pos_y         <= o.pos[1];
        obj_bus.pos_z         <= o.pos[2];
        obj_bus.offset_x      <= o.off[0];
        obj_bus.offset_y      <= o.off[1];
        obj_bus.offset_z      <= o.off[2];
        obj_bus.extent_x      <= o.ext[0];
        obj_bus.extent_y      <= o.ext[1];
        obj_bus.extent_z      <= o.ext[2];
        obj_bus.sphere_radius <= o.radius;
        do
            @(posedge clk);
        while (!(obj_bus.valid && obj_bus.ready));
        pending_visibility.push_back(predict_visible(o));
        object_count++;
    endtask

    // Stops sending and waits until every outstanding request has its result.
    task automatic drain();
        obj_bus.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_visibility.size() != 0);
    endtask

    // Planes are zero after reset, so every object must come back visible.
    task automatic test_reset_state();
        send_object(make_object(KIND_BOX, '{0, 0, 0}, '{0, 0, 0}, '{0, 0, 0}, 0));
        send_object(make_object(KIND_BOX, '{8388607, 8388607, 8388607},
                                '{8388607, 8388607, 8388607}, '{8388607, 8388607, 8388607},
                                8388607));
        send_object(make_object(KIND_SPHERE, '{-8388608, -8388608, -8388608},
                                '{-8388608, -8388608, -8388608}, '{0, 0, 0}, 8388607));
        send_object(make_object(KIND_NONE, '{-8388608, -8388608, -8388608},
                                '{8388607, 8388607, 8388607}, '{8388607, 8388607, 8388607}, 0));
        send_object(make_object(KIND_SPARE, '{-1, -1, -1}, '{-1, -1, -1},
                                '{8388607, 8388607, 8388607}, 8388607));
    endtask

    // Writes past the last plane index must leave the planes untouched.
    task automatic test_spare_index();
        plane_t planes_next [PLANE_COUNT];
        foreach (planes_next[i])
            planes_next[i] = '0;
        planes_next[0] = make_plane(-1, -1, -1, -1);
        drain();
        program_planes(planes_next);
        write_reg(REG_SPARE_A, make_plane(0, 0, 0, -(1 << 27)));
        write_reg(REG_SPARE_B, make_plane(0, 0, 0, -(1 << 27)));
        end_reg_writes();
        send_object(make_object(KIND_BOX, '{8388607, 8388607, 8388607}, '{0, 0, 0},
                                '{0, 0, 0}, 0));
        send_object(make_object(KIND_BOX, '{-8388608, -8388608, -8388608}, '{0, 0, 0},
                                '{0, 0, 0}, 0));
        send_object(make_object(KIND_NONE, '{-600, -600, 0}, '{0, 0, 0}, '{100, 100, 0}, 0));
    endtask

    // Left plane keeps x >= 0, right plane keeps x <= 1/256; a sum of exactly zero stays visible.
    task automatic test_plane_boundary();
        plane_t planes_next [PLANE_COUNT];
        foreach (planes_next[i])
            planes_next[i] = '0;
        planes_next[0] = make_plane(1024, 0, 0, 0);
        planes_next[1] = make_plane(-1024, 0, 0, 1);
        drain();
        program_planes(planes_next);
        send_object(make_object(KIND_BOX, '{-256, 0, 0}, '{0, 0, 0}, '{256, 0, 0}, 0));
        send_object(make_object(KIND_BOX, '{-257, 0, 0}, '{0, 0, 0}, '{256, 0, 0}, 0));
        send_object(make_object(KIND_BOX, '{257, 0, 0}, '{0, 0, 0}, '{256, 0, 0}, 0));
        send_object(make_object(KIND_BOX, '{258, 0, 0}, '{0, 0, 0}, '{256, 0, 0}, 0));
        send_object(make_object(KIND_SPHERE, '{0, 0, 0}, '{-300, 0, 0}, '{0, 0, 0}, 300));
        send_object(make_object(KIND_SPHERE, '{0, 0, 0}, '{-300, 0, 0}, '{0, 0, 0}, 299));
        // Without a collider the offset must be ignored.
        send_object(make_object(KIND_NONE, '{-256, 0, 0}, '{-1000, 0, 0}, '{256, 0, 0}, 0));
        send_object(make_object(KIND_SPARE, '{-256, 0, 0}, '{-1000, 0, 0}, '{256, 0, 0}, 0));
    endtask

    // Extreme normals and distances against extreme boxes exercise the full accumulator width.
    task automatic test_wide_extremes();
        plane_t planes_next [PLANE_COUNT];
        planes_next[0] = make_plane(2047, -2048, 2047, (1 << 27) - 1);
        planes_next[1] = make_plane(-2048, 2047, -2048, -(1 << 27));
        planes_next[2] = make_plane(0, 0, -2048, 0);
        planes_next[3] = make_plane(-1, -1, -1, -1);
        planes_next[4] = make_plane(-2048, -2048, -2048, (1 << 27) - 1);
        planes_next[5] = make_plane(2047, 2047, 2047, -(1 << 27));
        drain();
        program_planes(planes_next);
        send_object(make_object(KIND_BOX, '{8388607, 8388607, 8388607},
                                '{8388607, 8388607, 8388607}, '{8388607, 8388607, 8388607}, 0));
        send_object(make_object(KIND_BOX, '{-8388608, -8388608, -8388608},
                                '{-8388608, -8388608, -8388608}, '{8388607, 8388607, 8388607},
                                0));
        send_object(make_object(KIND_SPHERE, '{0, 0, 0}, '{0, 0, 0}, '{0, 0, 0}, 8388607));
    endtask

    // Four idling phases, each going through four plane settings, the last one raw random bits.
    task automatic test_random_traffic();
        plane_t planes_next [PLANE_COUNT];
        int src_pcts [4]   = '{0, 85, 0, 30};
        int stall_pcts [4] = '{0, 0, 85, 30};
        for (int phase = 0; phase < 4; phase++)
        begin
            for (int blk = 0; blk < 4; blk++)
            begin
                drain();
                src_idle_pct   = src_pcts[phase];
                sink_stall_pct = stall_pcts[phase];
                foreach (planes_next[i])
                    planes_next[i] = random_plane(blk == 3);
                program_planes(planes_next);
                repeat (100) send_object(random_object());
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            vis_bus.ready <= 1'b0;
        else
            vis_bus.ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge clk)
    begin
        bit want;
        if (rst_n && vis_bus.valid && vis_bus.ready)
        begin
            if (pending_visibility.size() == 0)
            begin
                $error("unexpected result request: visible %0b", vis_bus.visible);
                mismatch_count++;
            end
            else
            begin
                want = pending_visibility.pop_front();
                if (vis_bus.visible !== want)
                begin
                    $error("visible mismatch: expected %0b, actual %0b", want, vis_bus.visible);
                    mismatch_count++;
                end
                if (vis_bus.visible === 1'b1)
                    visible_count++;
                else
                    culled_count++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles with %0d results outstanding.",
                     cycle_count, pending_visibility.size());
            $display("tb_top: FAIL");
            $finish;
        end
    end

    initial
    begin
        object_count      = 0;
        plane_write_count = 0;
        src_idle_pct      = 0;
        sink_stall_pct    = 0;
        foreach (plane_regs[i])
            plane_regs[i] = '0;

        rst_n                 <= 1'b0;
        obj_bus.valid         <= 1'b0;
        obj_bus.shape_kind    <= '0;
        obj_bus.pos_x         <= '0;
        obj_bus.pos_y         <= '0;
        obj_bus.pos_z         <= '0;
        obj_bus.offset_x      <= '0;
        obj_bus.offset_y      <= '0;
        obj_bus.offset_z      <= '0;
        obj_bus.extent_x      <= '0;
        obj_bus.extent_y      <= '0;
        obj_bus.extent_z      <= '0;
        obj_bus.sphere_radius <= '0;
        cfg_bus.valid         <= 1'b0;
        cfg_bus.index         <= '0;
        cfg_bus.data          <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_spare_index();
        test_plane_boundary();
        test_wide_extremes();
        test_random_traffic();

        drain();
        // The pipeline is four deep; any extra result would show up well within this window.
        repeat (8) @(posedge clk);

        $display("Checked %0d object requests: %0d visible, %0d culled.",
                 object_count, visible_count, culled_count);
        $display("Made %0d plane register writes across directed and random settings.",
                 plane_write_count);
        if (mismatch_count == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
